FILE: rtl/teq_pkg.sv
// ----------------------------------------------------------------------------
// teq_pkg
// Shared types and constants for the timed event queue.
// ----------------------------------------------------------------------------
package teq_pkg;

    localparam int DEPTH    = 16;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int TICK_W   = 24;
    localparam logic [TICK_W-1:0] FAR_LIMIT = 24'h800000;

    localparam logic [1:0] CMD_SCHED  = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BAD_TIME = 2'd2;
    localparam logic [1:0] ST_NO_ID    = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_INSERT,
        S_REMOVE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;      // capture input word, start op
        logic walk;      // examine one list entry
        logic insert;    // shift one and place new entry
        logic remove;    // shift one for removal
        logic finish;    // result into output register
        logic out_take;  // output word taken
    } t_cmd;

    typedef struct packed {
        logic walk_done;
        logic need_insert;
        logic need_remove;
        logic shift_done;
    } t_stat;

endpackage

FILE: rtl/timed_event_queue.sv
// ----------------------------------------------------------------------------
// timed_event_queue
// Sorted queue of up to 16 timed events on a wrapping 24-bit tick counter.
// ----------------------------------------------------------------------------
// One word in, one result word out. A tick needs no walk; when the head fires
// the rest of the list shifts down one entry a cycle. Schedule and cancel walk
// the sorted list one entry a cycle up to the insert or hit position and then
// shift the entries behind it one a cycle, so walk and shift together cover
// the list once. A new word is taken once the result word has been taken.
module timed_event_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [23:0] i_event_time,
    input  logic [15:0] i_sub_tick,
    input  logic [15:0] i_action,
    input  logic [3:0]  i_cancel_id,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [3:0]  o_assigned_id,
    output logic        o_head_changed,
    output logic        o_fired,
    output logic [3:0]  o_fired_id,
    output logic [15:0] o_fired_sub_tick,
    output logic [15:0] o_fired_action
);

    teq_pkg::t_cmd  cmd;
    teq_pkg::t_stat stat;

    teq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_ready_out (i_ready),
        .i_stat      (stat),
        .o_ready     (o_ready),
        .o_valid     (o_valid),
        .o_cmd       (cmd)
    );

    teq_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_command        (i_command),
        .i_event_time     (i_event_time),
        .i_sub_tick       (i_sub_tick),
        .i_action         (i_action),
        .i_cancel_id      (i_cancel_id),
        .o_stat           (stat),
        .o_status         (o_status),
        .o_assigned_id    (o_assigned_id),
        .o_head_changed   (o_head_changed),
        .o_fired          (o_fired),
        .o_fired_id       (o_fired_id),
        .o_fired_sub_tick (o_fired_sub_tick),
        .o_fired_action   (o_fired_action)
    );

endmodule

FILE: rtl/teq_ctrl.sv
// ----------------------------------------------------------------------------
// teq_ctrl
// Sequencer for schedule, cancel and tick commands.
// ----------------------------------------------------------------------------
module teq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_ready_out,
    input  teq_pkg::t_stat i_stat,
    output logic           o_ready,
    output logic           o_valid,
    output teq_pkg::t_cmd  o_cmd
);

    teq_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= teq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            teq_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = teq_pkg::S_WALK;
                end
            end
            teq_pkg::S_WALK: begin
                if (i_stat.walk_done) begin
                    if (i_stat.need_insert) begin
                        n_state = teq_pkg::S_INSERT;
                    end else if (i_stat.need_remove) begin
                        n_state = teq_pkg::S_REMOVE;
                    end else begin
                        o_cmd.finish = 1'b1;
                        n_state      = teq_pkg::S_OUT;
                    end
                end else begin
                    o_cmd.walk = 1'b1;
                end
            end
            teq_pkg::S_INSERT: begin
                o_cmd.insert = 1'b1;
                if (i_stat.shift_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = teq_pkg::S_OUT;
                end
            end
            teq_pkg::S_REMOVE: begin
                o_cmd.remove = 1'b1;
                if (i_stat.shift_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = teq_pkg::S_OUT;
                end
            end
            teq_pkg::S_OUT: begin
                o_valid = 1'b1;
                if (i_ready_out) begin
                    o_cmd.out_take = 1'b1;
                    n_state        = teq_pkg::S_IDLE;
                end
            end
            default: n_state = teq_pkg::S_IDLE;
        endcase
    end

endmodule

FILE: rtl/teq_dp.sv
// ----------------------------------------------------------------------------
// teq_dp
// Slot store, sorted order list and walk/shift datapath.
// ----------------------------------------------------------------------------
module teq_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  teq_pkg::t_cmd             i_cmd,
    input  logic [1:0]                i_command,
    input  logic [23:0]               i_event_time,
    input  logic [15:0]               i_sub_tick,
    input  logic [15:0]               i_action,
    input  logic [3:0]                i_cancel_id,
    output teq_pkg::t_stat            o_stat,
    output logic [1:0]                o_status,
    output logic [3:0]                o_assigned_id,
    output logic                      o_head_changed,
    output logic                      o_fired,
    output logic [3:0]                o_fired_id,
    output logic [15:0]               o_fired_sub_tick,
    output logic [15:0]               o_fired_action
);

    localparam int IW = teq_pkg::IDX_W;
    localparam int CW = teq_pkg::CNT_W;
    localparam int D  = teq_pkg::DEPTH;

    logic [D-1:0]         r_valid;
    logic [23:0]          r_time [D];
    logic [15:0]          r_fine [D];
    logic [15:0]          r_tag  [D];
    logic [IW-1:0]        r_order [D];
    logic [CW-1:0]        r_count;
    logic [23:0]          r_now;

    logic [1:0]           r_cmd;
    logic [23:0]          r_etime;
    logic [15:0]          r_efine, r_etag;
    logic [3:0]           r_cid;
    logic [CW-1:0]        r_pos;     // walk index / shift index
    logic [CW-1:0]        r_ins;     // insert/remove position
    logic                 r_done, r_ins_go, r_rem_go;
    logic [1:0]           r_st;
    logic                 r_fire;
    logic [IW-1:0]        r_slot;

    logic [1:0]           r_o_status;
    logic [3:0]           r_o_asg, r_o_fid;
    logic                 r_o_hc, r_o_fired;
    logic [15:0]          r_o_fsub, r_o_fact;

    logic [IW-1:0]        free_slot;
    logic                 free_ok;
    logic [IW-1:0]        cur;
    logic [23:0]          nd, ed;
    logic [IW-1:0]        pidx;

    always_comb begin
        free_slot = '0;
        free_ok   = 1'b0;
        for (int k = D - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_slot = IW'(k);
                free_ok   = 1'b1;
            end
        end
    end

    assign pidx = r_pos[IW-1:0];
    assign cur  = r_order[pidx];
    assign nd   = r_etime - r_now;
    assign ed   = r_time[cur] - r_now;

    assign o_stat.walk_done   = r_done;
    assign o_stat.need_insert = r_ins_go;
    assign o_stat.need_remove = r_rem_go;
    assign o_stat.shift_done  = (i_cmd.insert && r_pos <= r_ins)
                             || (i_cmd.remove && r_pos + CW'(1) >= r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            r_now   <= '0;
            r_done  <= 1'b0;
            r_ins_go <= 1'b0;
            r_rem_go <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_cmd    <= i_command;
                r_etime  <= i_event_time;
                r_efine  <= i_sub_tick;
                r_etag   <= i_action;
                r_cid    <= i_cancel_id;
                r_pos    <= '0;
                r_ins    <= r_count;
                r_ins_go <= 1'b0;
                r_rem_go <= 1'b0;
                r_fire   <= 1'b0;
                r_st     <= teq_pkg::ST_OK;
                r_done   <= 1'b0;
                r_slot   <= free_slot;
                case (i_command)
                    teq_pkg::CMD_SCHED: begin
                        if (r_count >= CW'(D) || !free_ok) begin
                            r_st   <= teq_pkg::ST_FULL;
                            r_done <= 1'b1;
                        end else if ((i_event_time - r_now) >= teq_pkg::FAR_LIMIT) begin
                            r_st   <= teq_pkg::ST_BAD_TIME;
                            r_done <= 1'b1;
                        end
                    end
                    teq_pkg::CMD_CANCEL: begin
                        if (!r_valid[i_cancel_id[IW-1:0]]) begin
                            r_st   <= teq_pkg::ST_NO_ID;
                            r_done <= 1'b1;
                        end
                    end
                    teq_pkg::CMD_TICK: begin
                        r_now  <= r_now + 24'd1;
                        r_done <= 1'b1;
                        if (r_count != '0) begin
                            if ((r_time[r_order[0]] - r_now - 24'd1) == '0 ||
                                (r_time[r_order[0]] - r_now - 24'd1) >= teq_pkg::FAR_LIMIT) begin
                                r_fire   <= 1'b1;
                                r_slot   <= r_order[0];
                                r_ins    <= '0;
                                r_rem_go <= 1'b1;
                            end
                        end
                    end
                    default: r_done <= 1'b1;
                endcase
            end
            if (i_cmd.walk) begin
                if (r_pos >= r_count) begin
                    r_done <= 1'b1;
                    if (r_cmd == teq_pkg::CMD_SCHED) begin
                        r_ins_go <= 1'b1;
                        r_pos    <= r_count;
                    end
                end else if (r_cmd == teq_pkg::CMD_SCHED) begin
                    if (ed >= teq_pkg::FAR_LIMIT || ed == nd) begin
                        r_st   <= teq_pkg::ST_BAD_TIME;
                        r_done <= 1'b1;
                    end else if (nd < ed) begin
                        r_ins    <= r_pos;
                        r_ins_go <= 1'b1;
                        r_done   <= 1'b1;
                        r_pos    <= r_count;
                    end else begin
                        r_pos <= r_pos + CW'(1);
                    end
                end else begin
                    if (cur == r_cid[IW-1:0]) begin
                        r_ins    <= r_pos;
                        r_rem_go <= 1'b1;
                        r_done   <= 1'b1;
                    end else begin
                        r_pos <= r_pos + CW'(1);
                    end
                end
            end
            if (i_cmd.insert) begin
                if (r_pos > r_ins) begin
                    r_order[pidx] <= r_order[pidx - IW'(1)];
                    r_pos         <= r_pos - CW'(1);
                end else begin
                    r_order[pidx]   <= r_slot;
                    r_count         <= r_count + CW'(1);
                    r_valid[r_slot] <= 1'b1;
                    r_time[r_slot]  <= r_etime;
                    r_fine[r_slot]  <= r_efine;
                    r_tag[r_slot]   <= r_etag;
                end
            end
            if (i_cmd.remove) begin
                if (r_pos + CW'(1) < r_count) begin
                    r_order[pidx] <= r_order[pidx + IW'(1)];
                    r_pos         <= r_pos + CW'(1);
                end else begin
                    r_count <= r_count - CW'(1);
                    if (r_fire) begin
                        r_valid[r_slot] <= 1'b0;
                    end else begin
                        r_valid[r_cid[IW-1:0]] <= 1'b0;
                    end
                end
            end
            if (i_cmd.finish && r_cmd == teq_pkg::CMD_CANCEL
                    && r_st == teq_pkg::ST_OK && !r_rem_go) begin
                r_valid[r_cid[IW-1:0]] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_o_status <= r_st;
            r_o_asg    <= (r_ins_go) ? 4'(r_slot) : 4'd0;
            r_o_hc     <= ((r_ins_go || r_rem_go) && r_ins == '0) || r_fire;
            r_o_fired  <= r_fire;
            r_o_fid    <= r_fire ? 4'(r_slot) : 4'd0;
            r_o_fsub   <= r_fire ? r_fine[r_slot] : 16'd0;
            r_o_fact   <= r_fire ? r_tag[r_slot] : 16'd0;
        end
    end

    // remove starts with r_pos at the hit position
    always_comb begin
        o_status         = r_o_status;
        o_assigned_id    = r_o_asg;
        o_head_changed   = r_o_hc;
        o_fired          = r_o_fired;
        o_fired_id       = r_o_fid;
        o_fired_sub_tick = r_o_fsub;
        o_fired_action   = r_o_fact;
    end

endmodule
